/* hdl/amc_pkg.sv */
package amc_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] MODE_SCAN = 2'd0;
  localparam logic [1:0] MODE_EDGE = 2'd1;
  localparam logic [1:0] MODE_INFO = 2'd2;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_ROOT_ON_HIT = 1'b0;
  localparam logic REG_MATCH_TAKEN = 1'b1;

  localparam int MAX_WORDS      = 256;
  localparam int MAX_WORD_BYTES = 255;

  // Width used for range compares against the state count (up to 65536)
  localparam int CMP_W = 17;

  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
    logic [9:0] state_index;
    logic [9:0] next_state;
    logic [9:0] fail_state;
    logic       has_word;
    logic [7:0] word_id;
    logic [7:0] word_bytes;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       match_found;
    logic [7:0] match_id;
    logic [7:0] match_len;
    logic [9:0] state_after;
  } result_t;

  typedef struct packed {
    logic root_on_hit;
    logic match_taken;
  } cfg_t;

  typedef struct packed {
    logic       has;
    logic [7:0] id;
    logic [7:0] len;
  } word_t;

endpackage

/* hdl/amc_ram.sv */
module amc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/amc_seq.sv */
module amc_seq #(
  parameter int NUM_STATES    = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  amc_pkg::item_t   in_item_i,
  input  amc_pkg::cfg_t    cfg_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output amc_pkg::result_t out_res_o
);
  import amc_pkg::*;

  localparam int SW = $clog2(NUM_STATES);
  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int GW = SW + AW;
  localparam int CW = $clog2(NUM_STATES + 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_STEP, S_WORD} state_e;

  state_e         state_q, state_d;
  logic [SW-1:0]  s_q, s_d;
  logic [SW-1:0]  cur_q, cur_d;
  logic [7:0]     byte_q, byte_d;
  logic           byte_ok_q, byte_ok_d;
  logic [CW-1:0]  steps_q, steps_d;
  logic [GW-1:0]  clr_q, clr_d;
  logic           out_valid_q, out_valid_d;
  result_t        res_q, res_d;

  logic           goto_we;
  logic [GW-1:0]  goto_waddr;
  logic [SW-1:0]  goto_wdata;
  logic [SW-1:0]  goto_rdata;
  logic           fail_we;
  logic [SW-1:0]  fail_wdata;
  logic [SW-1:0]  fail_rdata;
  logic           word_we;
  logic [SW-1:0]  word_waddr;
  word_t          word_wdata;
  word_t          word_rdata;

  logic           in_acc;
  logic           sidx_ok, nxt_ok, fail_ok, byte_in_ok, word_ok;
  logic [SW-1:0]  sidx;
  logic           edge_hit;
  logic           out_load;
  logic           to_root;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign sidx       = SW'(in_item_i.state_index);

  assign sidx_ok    = CMP_W'(in_item_i.state_index) < CMP_W'(NUM_STATES);
  assign nxt_ok     = CMP_W'(in_item_i.next_state) < CMP_W'(NUM_STATES);
  assign fail_ok    = CMP_W'(in_item_i.fail_state) < CMP_W'(NUM_STATES);
  assign byte_in_ok = CMP_W'(in_item_i.byte_value) < CMP_W'(ALPHABET_SIZE);
  assign word_ok    = in_item_i.has_word && (in_item_i.state_index != '0)
                   && (CMP_W'(in_item_i.word_id) < CMP_W'(MAX_WORDS))
                   && (in_item_i.word_bytes != '0)
                   && (CMP_W'(in_item_i.word_bytes) <= CMP_W'(MAX_WORD_BYTES));

  // A byte outside the alphabet has no edge from any state
  assign edge_hit = byte_ok_q && (goto_rdata != '0);
  assign out_load = (state_q == S_WORD) && (!out_valid_q || out_ready_i);
  assign to_root  = word_rdata.has && (cfg_i.root_on_hit || cfg_i.match_taken);

  amc_ram #(.WIDTH(SW), .DEPTH(2 ** GW)) u_goto (
    .clk_i   (clk_i),
    .we_i    (goto_we),
    .waddr_i (goto_waddr),
    .wdata_i (goto_wdata),
    .raddr_i ({s_d, byte_d[AW-1:0]}),
    .rdata_o (goto_rdata)
  );

  amc_ram #(.WIDTH(SW), .DEPTH(2 ** SW)) u_fail (
    .clk_i   (clk_i),
    .we_i    (fail_we),
    .waddr_i (sidx),
    .wdata_i (fail_wdata),
    .raddr_i (s_d),
    .rdata_o (fail_rdata)
  );

  amc_ram #(.WIDTH($bits(word_t)), .DEPTH(2 ** SW)) u_word (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_wdata),
    .raddr_i (s_d),
    .rdata_o (word_rdata)
  );

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    cur_d       = cur_q;
    byte_d      = byte_q;
    byte_ok_d   = byte_ok_q;
    steps_d     = steps_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    goto_we     = 1'b0;
    goto_waddr  = clr_q;
    goto_wdata  = '0;
    fail_we     = 1'b0;
    fail_wdata  = fail_ok ? SW'(in_item_i.fail_state) : '0;
    word_we     = 1'b0;
    word_waddr  = clr_q[SW-1:0];
    word_wdata  = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Zero the edge and word stores, one entry a cycle
        goto_we = 1'b1;
        word_we = 1'b1;
        clr_d   = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_d       = cur_q;
        byte_d    = in_item_i.byte_value;
        byte_ok_d = byte_in_ok;
        steps_d   = '0;
        if (in_acc) begin
          unique case (in_item_i.mode)
            MODE_SCAN: begin
              state_d = S_STEP;
            end
            MODE_EDGE: begin
              if (sidx_ok && nxt_ok && byte_in_ok) begin
                goto_we    = 1'b1;
                goto_waddr = {sidx, in_item_i.byte_value[AW-1:0]};
                goto_wdata = SW'(in_item_i.next_state);
              end
            end
            MODE_INFO: begin
              if (sidx_ok) begin
                fail_we    = 1'b1;
                word_we    = 1'b1;
                word_waddr = sidx;
                if (word_ok) begin
                  word_wdata = '{has: 1'b1, id: in_item_i.word_id,
                                 len: in_item_i.word_bytes};
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_STEP: begin
        if (edge_hit) begin
          s_d     = goto_rdata;
          state_d = S_WORD;
        end else if (s_q == '0) begin
          state_d = S_WORD;
        end else if (steps_q >= CW'(NUM_STATES)) begin
          // Cyclic links: jump to root and try its edge once
          s_d = '0;
        end else begin
          s_d     = (CMP_W'(fail_rdata) < CMP_W'(NUM_STATES)) ? fail_rdata : '0;
          steps_d = steps_q + 1'b1;
        end
      end
      S_WORD: begin
        // Hold here while the output register is still occupied
        if (out_load) begin
          out_valid_d       = 1'b1;
          res_d.out_byte    = byte_q;
          res_d.match_found = word_rdata.has;
          res_d.match_id    = word_rdata.id;
          res_d.match_len   = word_rdata.len;
          res_d.state_after = to_root ? '0 : 10'(s_q);
          cur_d             = to_root ? '0 : s_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      s_q         <= '0;
      cur_q       <= '0;
      byte_q      <= '0;
      byte_ok_q   <= 1'b0;
      steps_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      s_q         <= s_d;
      cur_q       <= cur_d;
      byte_q      <= byte_d;
      byte_ok_q   <= byte_ok_d;
      steps_q     <= steps_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.match_found |-> res_q.match_id == '0 && res_q.match_len == '0)
    else $error("result without match carries a word");

  a_root_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && to_root |=> cur_q == '0 && res_q.state_after == '0)
    else $error("state not returned to root after match");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= CW'(NUM_STATES))
    else $error("fallback step count past state count");

  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cur_q) < CMP_W'(NUM_STATES))
    else $error("current state out of range");

endmodule

/* hdl/multi_pattern_byte_matcher.sv */
// Channel   Dir  Handshake                   Payload
// s_axis    in   tvalid/tready               tdata: item fields, tuser: mode
// m_axis    out  tvalid/tready               tdata: result fields, tuser: match_found
// apb       in   psel/penable/pwrite/pready  reg 0 root_on_hit, reg 1 match_taken
//
// After reset the edge and word stores are swept to zero, one entry a cycle;
// the edge store has 2**(clog2(NUM_STATES)+clog2(ALPHABET_SIZE)) entries, 262144 at the defaults.
// s_axis_tready_o stays low during the sweep; register writes are taken.
// Load items are written as they are accepted. A scan item walks failure-link
// steps in S_STEP, one more when a cyclic walk is cut off at the root, then S_WORD;
// each step is one read of the edge and link stores.
// A finished result sits in the output register, so the next item is accepted
// while it waits; a scan stalls in S_WORD only while that register is full and not read.
module multi_pattern_byte_matcher #(
  parameter int NUM_STATES    = 1024,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // byte_value[7:0] state_index[17:8] next_state[27:18] fail_state[37:28]
  // has_word[38] word_id[46:39] word_bytes[54:47], zero pad [55]
  input  logic [amc_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // mode[1:0]
  input  logic [amc_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // out_byte[7:0] match_id[15:8] match_len[23:16] state_after[33:24], zero pad [39:34]
  output logic [amc_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  // match_found[0]
  output logic [amc_pkg::OUT_USER_W-1:0]   m_axis_tuser_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import amc_pkg::*;

  item_t   item;
  result_t res;
  cfg_t    cfg_q, cfg_d;
  logic    reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      unique case (paddr[2])
        REG_ROOT_ON_HIT: cfg_d.root_on_hit = pwdata[0];
        REG_MATCH_TAKEN: cfg_d.match_taken = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{root_on_hit: 1'b1, match_taken: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROOT_ON_HIT: prdata = {31'd0, cfg_q.root_on_hit};
      REG_MATCH_TAKEN: prdata = {31'd0, cfg_q.match_taken};
      default:         prdata = '0;
    endcase
  end

  assign item.mode        = s_axis_tuser_i[1:0];
  assign item.byte_value  = s_axis_tdata_i[7:0];
  assign item.state_index = s_axis_tdata_i[17:8];
  assign item.next_state  = s_axis_tdata_i[27:18];
  assign item.fail_state  = s_axis_tdata_i[37:28];
  assign item.has_word    = s_axis_tdata_i[38];
  assign item.word_id     = s_axis_tdata_i[46:39];
  assign item.word_bytes  = s_axis_tdata_i[54:47];

  amc_seq #(
    .NUM_STATES    (NUM_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (item),
    .cfg_i       (cfg_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {6'd0, res.state_after, res.match_len, res.match_id, res.out_byte};
  assign m_axis_tuser_o = res.match_found;

endmodule

/* tb/multi_pattern_byte_matcher_tb.sv */
module multi_pattern_byte_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import amc_pkg::*;

  localparam int         STATES    = 1024;
  localparam int         SYMBOLS   = 256;
  localparam int         LIMIT     = 3_000_000;
  localparam int         QUIET     = 32;
  localparam int         TAIL      = 64;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  in_data;
  logic [IN_USER_W-1:0]  in_user;
  logic                  m_axis_tvalid_o;
  logic                  out_ready;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  multi_pattern_byte_matcher #(
    .NUM_STATES   (STATES),
    .ALPHABET_SIZE(SYMBOLS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(s_axis_tready_o),
    // byte_value, state_index, next_state, fail_state, has_word, word_id, word_bytes, pad
    .s_axis_tdata_i (in_data),
    // mode
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(out_ready),
    // out_byte, match_id, match_len, state_after, pad
    .m_axis_tdata_o (m_axis_tdata_o),
    // match_found
    .m_axis_tuser_o (m_axis_tuser_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  typedef struct packed {
    bit [9:0] src;
    bit [7:0] b;
  } arc_t;

  // Shadow automaton
  bit [9:0]    goto_mem       [STATES*SYMBOLS];
  bit [9:0]    link_mem       [STATES];
  bit          word_has       [STATES];
  bit [7:0]    word_id_mem    [STATES];
  bit [7:0]    word_bytes_mem [STATES];
  bit [9:0]    scan_state;
  bit          cfg_rom   = 1'b1;
  bit          cfg_taken = 1'b1;

  // States with a loaded link, in load order; pick_fail only links to earlier entries
  int unsigned known_states [$];
  int          pool_pos     [STATES];
  arc_t        arcs         [$];

  result_t     scan_results_q [$];

  bit          idle_on    = 1'b1;
  int          hold_left  = 0;
  int          stall_left = 0;
  int          err_cnt    = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          matches_seen    = 0;
  int          reg_writes      = 0;
  int          cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic int unsigned rand_word_bytes();
    if ($urandom_range(0, 9) == 0) return 0;
    return $urandom_range(1, 255);
  endfunction

  function automatic int unsigned pick_fail(int unsigned st);
    int lim;
    lim = (pool_pos[st] >= 0) ? pool_pos[st] : known_states.size();
    if (lim == 0 || $urandom_range(0, 3) == 0) return 0;
    return known_states[$urandom_range(0, lim - 1)];
  endfunction

  function automatic int unsigned pick_src();
    if (known_states.size() == 0 || $urandom_range(0, 99) < 35) return 0;
    return known_states[$urandom_range(0, known_states.size() - 1)];
  endfunction

  function automatic bit [7:0] next_scan_byte(bit follow);
    bit [7:0] cand [$];
    if (arcs.size() == 0) return 8'($urandom());
    if (follow) begin
      foreach (arcs[i]) begin
        if (arcs[i].src == scan_state && goto_mem[{arcs[i].src, arcs[i].b}] != 0)
          cand.push_back(arcs[i].b);
      end
    end
    if (cand.size() == 0) return arcs[$urandom_range(0, arcs.size() - 1)].b;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic void predict_scan(bit [7:0] b);
    bit [9:0] s;
    bit [9:0] nx;
    int       steps;
    result_t  r;
    s     = scan_state;
    steps = 0;
    while (1) begin
      nx = goto_mem[{s, b}];
      if (nx != 0) begin
        s = nx;
        break;
      end
      if (s == 0) break;
      // cyclic links: give up and retry from root once
      if (steps >= STATES) begin
        s = 0;
        continue;
      end
      s = link_mem[s];
      steps++;
    end
    r.out_byte    = b;
    r.match_found = word_has[s];
    r.match_id    = word_has[s] ? word_id_mem[s] : 8'd0;
    r.match_len   = word_has[s] ? word_bytes_mem[s] : 8'd0;
    if (word_has[s] && (cfg_rom || cfg_taken)) s = 0;
    r.state_after = s;
    scan_state    = s;
    scan_results_q.push_back(r);
  endfunction

  function automatic void apply_item(item_t it);
    bit ok;
    case (it.mode)
      MODE_EDGE: begin
        goto_mem[{it.state_index, it.byte_value}] = it.next_state;
        if (it.next_state != 0) arcs.push_back('{src: it.state_index, b: it.byte_value});
      end
      MODE_INFO: begin
        link_mem[it.state_index] = it.fail_state;
        ok = it.has_word && it.state_index != 0 && int'(it.word_id) < MAX_WORDS &&
             it.word_bytes != 0 && int'(it.word_bytes) <= MAX_WORD_BYTES;
        word_has[it.state_index]       = ok;
        word_id_mem[it.state_index]    = ok ? it.word_id : 8'd0;
        word_bytes_mem[it.state_index] = ok ? it.word_bytes : 8'd0;
        if (it.state_index != 0 && pool_pos[it.state_index] < 0) begin
          pool_pos[it.state_index] = known_states.size();
          known_states.push_back(it.state_index);
        end
      end
      MODE_SCAN: predict_scan(it.byte_value);
      default: ;
    endcase
  endfunction

  task automatic send_item(item_t it);
    int n;
    in_valid <= 1'b1;
    in_data  <= {1'b0, it.word_bytes, it.word_id, it.has_word, it.fail_state,
                 it.next_state, it.state_index, it.byte_value};
    in_user  <= it.mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_item(it);
    if (it.mode != MODE_NONE) items_sent++;
    n = idle_on ? gap_len() : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic load_info(int unsigned st, int unsigned fl, bit has,
                           int unsigned id, int unsigned len);
    item_t it;
    it             = '0;
    it.mode        = MODE_INFO;
    it.state_index = st[9:0];
    it.fail_state  = fl[9:0];
    it.has_word    = has;
    it.word_id     = id[7:0];
    it.word_bytes  = len[7:0];
    it.byte_value  = 8'($urandom());
    it.next_state  = 10'($urandom());
    send_item(it);
  endtask

  task automatic load_arc(int unsigned src, int unsigned b, int unsigned dst);
    item_t it;
    it             = '0;
    it.mode        = MODE_EDGE;
    it.state_index = src[9:0];
    it.byte_value  = b[7:0];
    it.next_state  = dst[9:0];
    it.fail_state  = 10'($urandom());
    it.word_id     = 8'($urandom());
    send_item(it);
  endtask

  task automatic scan_val(int unsigned b);
    item_t it;
    bit [63:0] raw;
    raw           = {$urandom(), $urandom()};
    it            = raw[$bits(item_t)-1:0];
    it.mode       = MODE_SCAN;
    it.byte_value = b[7:0];
    send_item(it);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (scan_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic reg_idx, bit [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_idx == REG_ROOT_ON_HIT) cfg_rom = val[0];
    else cfg_taken = val[0];
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(logic reg_idx, bit want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== want) begin
      $error("register %0d: expected %0d, got %0d", reg_idx, want, prdata[0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(bit rom, bit taken);
    bit [31:0] v;
    wait_drain();
    // let trailing table loads retire
    repeat (QUIET) @(posedge clk_i);
    v    = $urandom();
    v[0] = rom;
    apb_write(REG_ROOT_ON_HIT, v);
    v    = $urandom();
    v[0] = taken;
    apb_write(REG_MATCH_TAKEN, v);
    apb_check(REG_ROOT_ON_HIT, rom);
    apb_check(REG_MATCH_TAKEN, taken);
  endtask

  task automatic grow_automaton(int n);
    int unsigned st;
    for (int i = 0; i < n; i++) begin
      st = $urandom_range(1, STATES - 1);
      load_info(st, pick_fail(st), $urandom_range(0, 9) < 4, $urandom_range(0, 255),
                rand_word_bytes());
      load_arc(pick_src(), $urandom_range(0, 255), st);
    end
  endtask

  task automatic mixed_traffic(int n);
    int          done_cnt;
    int          r;
    int unsigned st;
    int unsigned dst;
    item_t       it;
    bit [63:0]   raw;
    done_cnt = 0;
    while (done_cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        scan_val(next_scan_byte(1'b1));
      end else if (r < 75) begin
        scan_val(next_scan_byte(1'b0));
      end else if (r < 83) begin
        scan_val($urandom_range(0, 255));
      end else if (r < 90) begin
        if (known_states.size() > 0 && $urandom_range(0, 1) == 1)
          st = known_states[$urandom_range(0, known_states.size() - 1)];
        else
          st = $urandom_range(1, STATES - 1);
        load_info(st, pick_fail(st), $urandom_range(0, 1), $urandom_range(0, 255),
                  rand_word_bytes());
      end else if (r < 96) begin
        if (known_states.size() == 0 || $urandom_range(0, 4) == 0) dst = 0;
        else dst = known_states[$urandom_range(0, known_states.size() - 1)];
        load_arc(pick_src(), $urandom_range(0, 255), dst);
      end else begin
        // unknown mode: dropped by the block, not counted
        raw     = {$urandom(), $urandom()};
        it      = raw[$bits(item_t)-1:0];
        it.mode = MODE_NONE;
        send_item(it);
        continue;
      end
      done_cnt++;
    end
  endtask

  task automatic test_registers();
    apb_check(REG_ROOT_ON_HIT, 1'b1);
    apb_check(REG_MATCH_TAKEN, 1'b1);
    set_config(1'b0, 1'b1);
    set_config(1'b1, 1'b1);
  endtask

  task automatic test_directed();
    item_t it;
    load_info(1, 0, 1'b1, 0, 1);
    load_info(1023, 0, 1'b0, 8'hA5, 8'h5A);
    load_info(512, 1, 1'b1, 255, 255);
    load_arc(0, 8'hFF, 1023);
    load_arc(1023, 8'h00, 512);
    load_arc(0, 8'h00, 1);
    scan_val(8'hFF);
    scan_val(8'h00);
    scan_val(8'h00);
    scan_val(8'h41);
    scan_val(8'hFF);
    scan_val(8'hFF);
    scan_val(8'h41);
    // stay in the matched state, then fall back through the link
    set_config(1'b0, 1'b0);
    scan_val(8'hFF);
    scan_val(8'h00);
    scan_val(8'h00);
    // root never holds a word; zero length stores none
    load_info(0, 1023, 1'b1, 7, 3);
    load_info(1023, 0, 1'b1, 9, 0);
    it      = '1;
    it.mode = MODE_NONE;
    send_item(it);
    // two states linked to each other with no outgoing arcs
    load_info(701, 700, 1'b0, 0, 0);
    load_info(700, 701, 1'b0, 0, 0);
    load_arc(0, 8'h10, 700);
    scan_val(8'h10);
    scan_val(8'h20);
    scan_val(8'h10);
    scan_val(8'hFF);
    // break the loop before random traffic
    load_info(701, 0, 1'b0, 0, 0);
  endtask

  task automatic test_output_stall();
    wait_drain();
    idle_on   = 1'b0;
    hold_left = 400;
    repeat (40) scan_val(next_scan_byte(1'b1));
    wait_drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      set_config(p[0], p[1]);
      idle_on = (p != 2);
      grow_automaton(10);
      mixed_traffic(100);
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  initial begin : result_checker
    result_t got;
    result_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && out_ready) begin
        got.out_byte    = m_axis_tdata_o[7:0];
        got.match_id    = m_axis_tdata_o[15:8];
        got.match_len   = m_axis_tdata_o[23:16];
        got.state_after = m_axis_tdata_o[33:24];
        got.match_found = m_axis_tuser_o[0];
        if (scan_results_q.size() == 0) begin
          $error("result with nothing pending: out_byte %0d", got.out_byte);
          err_cnt++;
        end else begin
          want = scan_results_q.pop_front();
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("match_found", want.match_found, got.match_found);
          check_field("match_id", want.match_id, got.match_id);
          check_field("match_len", want.match_len, got.match_len);
          check_field("state_after", want.state_after, got.state_after);
          results_checked++;
          if (want.match_found) matches_seen++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("multi_pattern_byte_matcher_tb: done, errors");
    $finish;
  end

  initial begin
    foreach (pool_pos[i]) pool_pos[i] = -1;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    in_user   <= '0;
    out_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_registers();
    test_directed();
    test_output_stall();
    test_random_traffic();

    wait_drain();
    repeat (TAIL) @(posedge clk_i);
    $display("Ran %0d scan and table-load items over all four match-return settings,",
             items_sent);
    $display("checked %0d results (%0d matches), %0d register writes, %0d cycles",
             results_checked, matches_seen, reg_writes, cycle_cnt);
    if (err_cnt == 0) begin
      $display("multi_pattern_byte_matcher_tb: done, clean");
    end else begin
      $display("multi_pattern_byte_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule
